FILE: design/srdm_pkg.sv
// shared types and constants for the stick radial deadzone merge unit
`timescale 1ns / 1ps
`default_nettype none

package srdm_pkg;

    // deadzone radius register
    localparam int RADIUS_BITS = 15;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 15'd5898;
    localparam logic [29:0] RAD_SQ_RESET = 30'(5898 * 5898);
    localparam logic [31:0] SPAN_RESET = 32'h8000_0000 - 32'(5898 * 65536);

    // pipeline stage map
    localparam int ST_SQ      = 0;
    localparam int ST_SUM     = 1;
    localparam int ST_ROOT0   = 2;
    localparam int ROOT_STAGES = 16;
    localparam int ST_SPAN    = ST_ROOT0 + ROOT_STAGES;
    localparam int ST_RDIV0   = ST_SPAN + 1;
    localparam int RDIV_STAGES = 12;
    localparam int ST_MUL     = ST_RDIV0 + RDIV_STAGES;
    localparam int ST_ADIV0   = ST_MUL + 1;
    localparam int ADIV_STAGES = 12;
    localparam int ST_ROUND   = ST_ADIV0 + ADIV_STAGES;
    localparam int ST_POW     = ST_ROUND + 1;
    localparam int NSTAGE     = ST_POW + 1;

    // integer square root state, two result bits per stage
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [31:0] bits;
    } root_t;

    // restoring divider state, two quotient bits per stage
    typedef struct packed {
        logic [31:0] rem;
        logic [23:0] num;
        logic [24:0] quo;
    } div_t;

    typedef struct packed {
        logic              sgn_x;
        logic              sgn_y;
        logic [15:0]       mag_x;
        logic [15:0]       mag_y;
        logic signed [7:0] cur_x;
        logic signed [7:0] cur_y;
        logic [31:0]       sq_x;
        logic [31:0]       sq_y;
        logic              live;
        root_t             rt;
        div_t              rdiv;
        div_t              dx;
        div_t              dy;
        logic signed [7:0] ax;
        logic signed [7:0] ay;
        logic [15:0]       src2;
        logic [15:0]       cur2;
    } pipe_t;

endpackage

`default_nettype wire

FILE: design/srdm_if.sv
// valid/ready channels for stick samples and merged results
`timescale 1ns / 1ps
`default_nettype none

interface srdm_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] source_x;
    logic signed [15:0] source_y;
    logic signed [7:0]  current_x;
    logic signed [7:0]  current_y;

    modport source (output valid, output source_x, output source_y,
                    output current_x, output current_y, input ready);
    modport sink   (input valid, input source_x, input source_y,
                    input current_x, input current_y, output ready);
endinterface

interface srdm_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] merged_x;
    logic signed [7:0] merged_y;
    logic              source_won;

    modport source (output valid, output merged_x, output merged_y,
                    output source_won, input ready);
    modport sink   (input valid, input merged_x, input merged_y,
                    input source_won, output ready);
endinterface

`default_nettype wire

FILE: design/srdm_root_step.sv
// two iterations of the digit-by-digit integer square root
`timescale 1ns / 1ps
`default_nettype none

module srdm_root_step (
    input  srdm_pkg::root_t i_state,
    output srdm_pkg::root_t o_state
);
    import srdm_pkg::*;

    always_comb
    begin
        root_t       t;
        logic [35:0] acc;
        logic [35:0] trial;
        t = i_state;
        for (int k = 0; k < 2; k++)
        begin
            acc   = {t.rem, t.bits[31:30]};
            trial = {2'b00, t.root, 2'b01};
            if (acc >= trial)
            begin
                t.rem  = 34'(acc - trial);
                t.root = {t.root[30:0], 1'b1};
            end
            else
            begin
                t.rem  = acc[33:0];
                t.root = {t.root[30:0], 1'b0};
            end
            t.bits = {t.bits[29:0], 2'b00};
        end
        o_state = t;
    end

endmodule

`default_nettype wire

FILE: design/srdm_div_step.sv
// two iterations of restoring division, numerator bits shifted in from num
`timescale 1ns / 1ps
`default_nettype none

module srdm_div_step (
    input  srdm_pkg::div_t  i_state,
    input  logic [31:0]     divisor,
    output srdm_pkg::div_t  o_state
);
    import srdm_pkg::*;

    always_comb
    begin
        div_t        t;
        logic [32:0] acc;
        logic        ge;
        t = i_state;
        for (int k = 0; k < 2; k++)
        begin
            acc = {t.rem, t.num[23]};
            ge  = (acc >= {1'b0, divisor});
            if (ge)
            begin
                t.rem = 32'(acc - {1'b0, divisor});
            end
            else
            begin
                t.rem = acc[31:0];
            end
            t.num = {t.num[22:0], 1'b0};
            t.quo = {t.quo[23:0], ge};
        end
        o_state = t;
    end

endmodule

`default_nettype wire

FILE: design/stick_radial_deadzone_merge_unit.sv
// top level: radial deadzone conversion of a stick sample merged into the pad value
`timescale 1ns / 1ps
`default_nettype none

// Takes one stick sample and the current pad stick value per cycle while ready
// is high and returns one merged value per item from the output register, at a
// sustained rate of one item per cycle while the output is not stalled. In the
// 46-stage pipeline, the square root unit and both dividers resolve two result
// bits per stage (16 stages for the root, 12 for the normalizing divide, 12 for
// the per-axis divides). A stalled output holds the pipeline; a bubble in the
// last stage is still filled while the output waits. A write to the deadzone
// radius takes effect on items accepted at the edge of the write or later; write
// it only while no item is in flight.
module stick_radial_deadzone_merge_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [srdm_pkg::RADIUS_BITS-1:0] cfg_wdata,
    srdm_in_if.sink                         sample,
    srdm_out_if.source                      result
);
    import srdm_pkg::*;

    localparam int LAST = NSTAGE - 1;

    logic [RADIUS_BITS-1:0] radius_reg;
    logic [29:0]            rad_sq_reg;
    logic [31:0]            span_reg;

    pipe_t              stage_reg  [NSTAGE];
    pipe_t              stage_next [NSTAGE];
    logic [NSTAGE-1:0]  v_reg;

    logic              out_valid_reg;
    logic signed [7:0] out_x_reg;
    logic signed [7:0] out_y_reg;
    logic              out_won_reg;

    logic en_pipe;
    logic out_load;

    assign out_load     = !out_valid_reg || result.ready;
    assign en_pipe      = !(v_reg[LAST] && !out_load);
    assign sample.ready = en_pipe;

    // radius with its square and the remap span kept alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            rad_sq_reg <= RAD_SQ_RESET;
            span_reg   <= SPAN_RESET;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_wdata;
            rad_sq_reg <= {15'd0, cfg_wdata} * {15'd0, cfg_wdata};
            span_reg   <= 32'h8000_0000 - {1'b0, cfg_wdata, 16'd0};
        end
    end

    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_stage
        if (s == ST_SQ)
        begin : g_sq
            pipe_t              nxt;
            logic signed [31:0] xs;
            logic signed [31:0] ys;
            assign xs = 32'(sample.source_x);
            assign ys = 32'(sample.source_y);
            always_comb
            begin
                nxt       = '0;
                nxt.sgn_x = sample.source_x[15];
                nxt.sgn_y = sample.source_y[15];
                nxt.mag_x = sample.source_x[15] ? 16'(-sample.source_x) : sample.source_x;
                nxt.mag_y = sample.source_y[15] ? 16'(-sample.source_y) : sample.source_y;
                nxt.cur_x = sample.current_x;
                nxt.cur_y = sample.current_y;
                nxt.sq_x  = xs * xs;
                nxt.sq_y  = ys * ys;
            end
            assign stage_next[s] = nxt;
        end
        else if (s == ST_SUM)
        begin : g_sum
            pipe_t       nxt;
            logic [31:0] s2;
            assign s2 = stage_reg[s-1].sq_x + stage_reg[s-1].sq_y;
            always_comb
            begin
                nxt         = stage_reg[s-1];
                nxt.live    = (s2 > {2'b00, rad_sq_reg});
                nxt.rt.rem  = '0;
                nxt.rt.root = '0;
                nxt.rt.bits = s2;
            end
            assign stage_next[s] = nxt;
        end
        else if (s < ST_SPAN)
        begin : g_root
            pipe_t nxt;
            root_t rt_o;
            srdm_root_step u_root (
                .i_state (stage_reg[s-1].rt),
                .o_state (rt_o)
            );
            always_comb
            begin
                nxt    = stage_reg[s-1];
                nxt.rt = rt_o;
            end
            assign stage_next[s] = nxt;
        end
        else if (s == ST_SPAN)
        begin : g_span
            pipe_t       nxt;
            logic [31:0] m;
            logic [31:0] d31;
            logic [31:0] nn;
            assign m   = stage_reg[s-1].rt.root;
            assign d31 = {1'b0, radius_reg, 16'd0};
            assign nn  = (m > d31) ? (m - d31) : 32'd0;
            // magnitude at full deflection or beyond saturates the ratio to one
            always_comb
            begin
                nxt          = stage_reg[s-1];
                nxt.rdiv.rem = m[31] ? 32'd0 : nn;
                nxt.rdiv.num = '0;
                nxt.rdiv.quo = {24'd0, m[31]};
            end
            assign stage_next[s] = nxt;
        end
        else if (s < ST_MUL)
        begin : g_rdiv
            pipe_t nxt;
            div_t  d_o;
            srdm_div_step u_div (
                .i_state (stage_reg[s-1].rdiv),
                .divisor (span_reg),
                .o_state (d_o)
            );
            always_comb
            begin
                nxt      = stage_reg[s-1];
                nxt.rdiv = d_o;
            end
            assign stage_next[s] = nxt;
        end
        else if (s == ST_MUL)
        begin : g_mul
            pipe_t       nxt;
            logic [22:0] kx;
            logic [22:0] ky;
            logic [47:0] px;
            logic [47:0] py;
            assign kx = {stage_reg[s-1].mag_x, 7'd0} - {7'd0, stage_reg[s-1].mag_x};
            assign ky = {stage_reg[s-1].mag_y, 7'd0} - {7'd0, stage_reg[s-1].mag_y};
            assign px = {25'd0, kx} * {23'd0, stage_reg[s-1].rdiv.quo};
            assign py = {25'd0, ky} * {23'd0, stage_reg[s-1].rdiv.quo};
            // numerator is the product shifted up by 8; the top part seeds the remainder
            always_comb
            begin
                nxt        = stage_reg[s-1];
                nxt.dx.rem = px[47:16];
                nxt.dx.num = {px[15:0], 8'd0};
                nxt.dx.quo = '0;
                nxt.dy.rem = py[47:16];
                nxt.dy.num = {py[15:0], 8'd0};
                nxt.dy.quo = '0;
            end
            assign stage_next[s] = nxt;
        end
        else if (s < ST_ROUND)
        begin : g_adiv
            pipe_t nxt;
            div_t  dx_o;
            div_t  dy_o;
            srdm_div_step u_div_x (
                .i_state (stage_reg[s-1].dx),
                .divisor (stage_reg[s-1].rt.root),
                .o_state (dx_o)
            );
            srdm_div_step u_div_y (
                .i_state (stage_reg[s-1].dy),
                .divisor (stage_reg[s-1].rt.root),
                .o_state (dy_o)
            );
            always_comb
            begin
                nxt    = stage_reg[s-1];
                nxt.dx = dx_o;
                nxt.dy = dy_o;
            end
            assign stage_next[s] = nxt;
        end
        else if (s == ST_ROUND)
        begin : g_round
            pipe_t       nxt;
            logic [24:0] rx;
            logic [24:0] ry;
            logic [6:0]  vx;
            logic [6:0]  vy;
            assign rx = {1'b0, stage_reg[s-1].dx.quo[23:0]} + 25'h8000;
            assign ry = {1'b0, stage_reg[s-1].dy.quo[23:0]} + 25'h8000;
            assign vx = (rx[24:16] > 9'd127) ? 7'd127 : rx[22:16];
            assign vy = (ry[24:16] > 9'd127) ? 7'd127 : ry[22:16];
            // sign goes on after rounding so halves round away from zero
            always_comb
            begin
                nxt = stage_reg[s-1];
                if (stage_reg[s-1].live)
                begin
                    nxt.ax = stage_reg[s-1].sgn_x ? -$signed({1'b0, vx}) : $signed({1'b0, vx});
                    nxt.ay = stage_reg[s-1].sgn_y ? -$signed({1'b0, vy}) : $signed({1'b0, vy});
                end
                else
                begin
                    nxt.ax = '0;
                    nxt.ay = '0;
                end
            end
            assign stage_next[s] = nxt;
        end
        else
        begin : g_pow
            pipe_t              nxt;
            logic signed [15:0] ax2;
            logic signed [15:0] ay2;
            logic signed [15:0] cx2;
            logic signed [15:0] cy2;
            assign ax2 = 16'(stage_reg[s-1].ax) * 16'(stage_reg[s-1].ax);
            assign ay2 = 16'(stage_reg[s-1].ay) * 16'(stage_reg[s-1].ay);
            assign cx2 = 16'(stage_reg[s-1].cur_x) * 16'(stage_reg[s-1].cur_x);
            assign cy2 = 16'(stage_reg[s-1].cur_y) * 16'(stage_reg[s-1].cur_y);
            always_comb
            begin
                nxt      = stage_reg[s-1];
                nxt.src2 = 16'(ax2) + 16'(ay2);
                nxt.cur2 = 16'(cx2) + 16'(cy2);
            end
            assign stage_next[s] = nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en_pipe)
        begin
            v_reg <= {v_reg[NSTAGE-2:0], sample.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_pipe)
        begin
            for (int s = 0; s < NSTAGE; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    // output register; ties keep the current pad value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= v_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && v_reg[LAST])
        begin
            out_won_reg <= (stage_reg[LAST].src2 > stage_reg[LAST].cur2);
            if (stage_reg[LAST].src2 > stage_reg[LAST].cur2)
            begin
                out_x_reg <= stage_reg[LAST].ax;
                out_y_reg <= stage_reg[LAST].ay;
            end
            else
            begin
                out_x_reg <= stage_reg[LAST].cur_x;
                out_y_reg <= stage_reg[LAST].cur_y;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.merged_x   = out_x_reg;
    assign result.merged_y   = out_y_reg;
    assign result.source_won = out_won_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> v_reg[0])
        else $error("accepted item did not enter the first stage");

    a_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_MUL-1] |-> stage_reg[ST_MUL-1].rdiv.quo <= 25'h100_0000)
        else $error("normalized magnitude above one");

    a_axis_q: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_ROUND-1] && stage_reg[ST_ROUND-1].live
        |-> !stage_reg[ST_ROUND-1].dx.quo[23] && !stage_reg[ST_ROUND-1].dy.quo[23])
        else $error("axis quotient out of range");

    a_won_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.source_won |-> (result.merged_x != 0 || result.merged_y != 0))
        else $error("source won with a zero stick");

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST] && !sample.ready |=> v_reg[LAST] && $stable(stage_reg[LAST]))
        else $error("last stage changed during a stall");

endmodule

`default_nettype wire

FILE: bench/tb_stick_radial_deadzone_merge_unit.sv
// testbench for the stick radial deadzone merge unit: queued driver, self-checking monitor
`timescale 1ns / 1ps

module tb_stick_radial_deadzone_merge_unit;
    import srdm_pkg::*;

    localparam int LATENCY   = 47;
    localparam int MAX_CYCLE = 600000;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [7:0]  cx;
        logic signed [7:0]  cy;
    } sample_t;

    typedef struct {
        logic signed [7:0] mx;
        logic signed [7:0] my;
        logic              won;
    } merged_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [RADIUS_BITS-1:0] cfg_wdata;

    srdm_in_if  sample ();
    srdm_out_if result ();

    stick_radial_deadzone_merge_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (sample),
        .result    (result)
    );

    sample_t pending_samples[$];
    merged_t merged_expected[$];
    logic [RADIUS_BITS-1:0] radius_shadow;
    bit failed;
    bit idle_on;
    int send_gap;
    int recv_gap;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [7:0] axis_scale(input longint a, input longint unsigned r,
                                                     input longint unsigned m);
        longint unsigned mag;
        longint unsigned q;
        longint unsigned v;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        q = (mag * 127 * r) / m;
        v = (q + 32768) >> 16;
        if (v > 127)
            v = 127;
        return (a < 0) ? -8'(v) : 8'(v);
    endfunction

    // converted stick only, ignoring the current pad value
    function automatic void convert_stick(input sample_t s, input logic [14:0] rad,
                                          output logic signed [7:0] ox,
                                          output logic signed [7:0] oy);
        longint x;
        longint y;
        longint unsigned d;
        longint unsigned m2;
        longint unsigned m;
        longint unsigned d31;
        longint unsigned span;
        longint unsigned n;
        longint unsigned r;
        x = longint'(s.sx) * 256;
        y = longint'(s.sy) * 256;
        d = longint'(rad) << 8;
        m2 = longint'(x * x) + longint'(y * y);
        ox = 0;
        oy = 0;
        if (m2 > d * d)
        begin
            m = int_sqrt(m2 << 16);
            d31 = d << 8;
            span = (64'd1 << 31) - d31;
            n = (m > d31) ? m - d31 : 0;
            if (n > span)
                n = span;
            r = (n << 24) / span;
            ox = axis_scale(x, r, m);
            oy = axis_scale(y, r, m);
        end
    endfunction

    function automatic merged_t predict_merge(input sample_t s, input logic [14:0] rad);
        merged_t e;
        logic signed [7:0] vx;
        logic signed [7:0] vy;
        int src2;
        int cur2;
        convert_stick(s, rad, vx, vy);
        src2 = int'(vx) * int'(vx) + int'(vy) * int'(vy);
        cur2 = int'(s.cx) * int'(s.cx) + int'(s.cy) * int'(s.cy);
        e.won = src2 > cur2;
        e.mx = e.won ? vx : s.cx;
        e.my = e.won ? vy : s.cy;
        return e;
    endfunction

    // driver: pops pending items, holds each until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample.valid     <= 1'b0;
            sample.source_x  <= '0;
            sample.source_y  <= '0;
            sample.current_x <= '0;
            sample.current_y <= '0;
            send_gap = 0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                sample_t acc;
                acc.sx = sample.source_x;
                acc.sy = sample.source_y;
                acc.cx = sample.current_x;
                acc.cy = sample.current_y;
                merged_expected.push_back(predict_merge(acc, radius_shadow));
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 13);
            end
            if (!sample.valid || sample.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_t nxt;
                    nxt = pending_samples.pop_front();
                    sample.valid     <= 1'b1;
                    sample.source_x  <= nxt.sx;
                    sample.source_y  <= nxt.sy;
                    sample.current_x <= nxt.cx;
                    sample.current_y <= nxt.cy;
                end
                else
                    sample.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result item and throttles ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            recv_gap = 0;
            cycle_count = 0;
        end
        else
        begin
            cycle_count++;
            if (cycle_count > MAX_CYCLE)
            begin
                $display("stick_radial_deadzone_merge_unit: mismatch");
                $finish;
            end
            if (result.valid && result.ready)
            begin
                if (merged_expected.size() == 0)
                begin
                    failed = 1'b1;
                    $display("%0t unexpected item x=%0d y=%0d won=%0b", $time,
                             result.merged_x, result.merged_y, result.source_won);
                end
                else
                begin
                    merged_t e;
                    e = merged_expected.pop_front();
                    if (result.merged_x !== e.mx)
                    begin
                        failed = 1'b1;
                        $display("%0t merged_x expected %0d actual %0d", $time, e.mx,
                                 result.merged_x);
                    end
                    if (result.merged_y !== e.my)
                    begin
                        failed = 1'b1;
                        $display("%0t merged_y expected %0d actual %0d", $time, e.my,
                                 result.merged_y);
                    end
                    if (result.source_won !== e.won)
                    begin
                        failed = 1'b1;
                        $display("%0t source_won expected %0b actual %0b", $time, e.won,
                                 result.source_won);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                result.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 12);
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    task automatic add_sample(input int sx, input int sy, input int cx, input int cy);
        sample_t s;
        s.sx = 16'(sx);
        s.sy = 16'(sy);
        s.cx = 8'(cx);
        s.cy = 8'(cy);
        pending_samples.push_back(s);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || sample.valid || merged_expected.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_radius(input logic [RADIUS_BITS-1:0] v);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        radius_shadow = v;
        repeat (3) @(posedge clk);
    endtask

    task automatic add_random(input int count);
        sample_t s;
        logic signed [7:0] vx;
        logic signed [7:0] vy;
        int k;
        int rr;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 9);
            s.sx = 16'($urandom);
            s.sy = 16'($urandom);
            s.cx = 8'($urandom);
            s.cy = 8'($urandom);
            if (k < 3)
            begin
                // near the deadzone edge
                rr = int'(radius_shadow) + $urandom_range(0, 64) - 32;
                s.sx = ($urandom_range(0, 1) != 0) ? 16'(rr) : -16'(rr);
                s.sy = 16'($urandom_range(0, 64)) - 16'sd32;
            end
            else if (k < 5)
            begin
                // small current value so the sample usually wins
                s.cx = 8'($urandom_range(0, 20)) - 8'sd10;
                s.cy = 8'($urandom_range(0, 20)) - 8'sd10;
            end
            else if (k < 7)
            begin
                // equal strength, rotated by a quarter turn
                convert_stick(s, radius_shadow, vx, vy);
                s.cx = vy;
                s.cy = -vx;
            end
            pending_samples.push_back(s);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        idle_on = 1'b1;
        radius_shadow = RADIUS_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and corners at the reset radius
        add_sample(0, 0, 0, 0);
        add_sample(32767, 0, 0, 0);
        add_sample(-32768, 0, 0, 0);
        add_sample(0, -32768, 0, 0);
        add_sample(0, 32767, 0, 0);
        add_sample(-32768, -32768, 0, 0);
        add_sample(32767, 32767, -128, -128);
        add_sample(32767, -32768, 127, 127);
        add_sample(5898, 0, 0, 0);
        add_sample(5899, 0, 0, 0);
        add_sample(0, -5899, 0, 0);
        add_sample(32767, 0, 127, 0);
        add_sample(32767, 0, 0, -127);
        add_sample(-32768, 0, 126, 0);
        add_sample(16000, 12000, -128, 127);
        add_sample(-1, -1, 1, 0);
        add_sample(0, 0, -1, 0);
        add_random(300);

        write_radius(15'd0);
        add_sample(0, 0, 0, 0);
        add_sample(1, 0, 0, 0);
        add_sample(-1, 0, 0, 0);
        add_random(300);

        write_radius(15'd31130);
        add_sample(31130, 0, 0, 0);
        add_sample(31131, 0, 0, 0);
        add_sample(-32768, 0, 0, 0);
        add_random(300);

        write_radius(15'h7FFF);
        add_sample(-32768, 0, 0, 0);
        add_sample(32767, 32767, 0, 0);
        add_random(200);

        write_radius(RADIUS_BITS'($urandom_range(0, 31130)));
        add_random(300);

        write_radius(RADIUS_RESET);
        add_random(150);
        wait_drained();
        idle_on = 1'b0;
        add_random(150);
        wait_drained();

        if (!failed)
            $display("stick_radial_deadzone_merge_unit: match");
        else
            $display("stick_radial_deadzone_merge_unit: mismatch");
        $finish;
    end
endmodule
